// ----- rtl/preemptive_priority_scheduler_macros.svh -----
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define PPS_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define PPS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/pps_pkg.sv -----
package pps_pkg;

  localparam int ACT_W    = 2;
  localparam int ARR_W    = 16;
  localparam int BUR_W    = 16;
  localparam int PRI_W    = 8;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int PID_W    = 5;

  typedef logic [ACT_W-1:0]    action_t;
  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Action codes; the unused code runs a tick.
  localparam action_t ACT_CLEAR = 2'd0;
  localparam action_t ACT_LOAD  = 2'd1;
  localparam action_t ACT_TICK  = 2'd2;

  localparam status_t STAT_RAN      = 3'd0;
  localparam status_t STAT_IDLE     = 3'd1;
  localparam status_t STAT_LOADED   = 3'd2;
  localparam status_t STAT_REJECTED = 3'd3;
  localparam status_t STAT_CLEARED  = 3'd4;

  localparam time_t TIME_MAX = '1;

  // One row of the process table memory.
  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [BUR_W-1:0] remaining;
    logic [PRI_W-1:0] priority_lvl;
    time_t            start_time;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  function automatic time_t sat_inc(time_t v);
    return (v == TIME_MAX) ? v : v + time_t'(1);
  endfunction

endpackage

// ----- rtl/preemptive_priority_scheduler.sv -----
// Preemptive priority scheduler over a table of MAX_PROCS processes.
//
// Command channel: drive start with in_action and the load fields; the word
// is taken at a rising edge with start high and busy low. Clear empties the
// table and resets time; load appends a process at the next free slot
// (pid = slot + 1); tick runs the best arrived, unfinished process for one
// time unit (higher priority, then earlier arrival, then lower pid).
//
// Result channel: every command yields one result word, shown for exactly
// one cycle with out_valid high. The receiver cannot stall it; the word is
// gone after that cycle.
//
// Timing: clear and load never raise busy; their result appears the cycle
// after acceptance. A tick reads the table memory one row a cycle over the
// N loaded rows, with busy high through the scan and finish states; its
// result word is registered out of the finish state.
//
// Reset (rst_n low, synchronous) empties the table, zeroes time and the
// idle count and drops any result in flight. The table memory itself is
// not cleared; rows at or above the process count are never compared.
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [ACT_W-1:0]    in_action,
  input  logic [ARR_W-1:0]    in_arrival,
  input  logic [BUR_W-1:0]    in_burst,
  input  logic [PRI_W-1:0]    in_priority_req,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [PID_W-1:0]    out_pid,
  output logic                out_completed,
  output logic [TIME_W-1:0]   out_completion_time,
  output logic [TIME_W-1:0]   out_turnaround,
  output logic [TIME_W-1:0]   out_waiting,
  output logic [TIME_W-1:0]   out_response,
  output logic [TIME_W-1:0]   out_idle_ticks,
  output logic                out_all_done
);

  `include "preemptive_priority_scheduler_macros.svh"

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);

  // Process table: one synchronous memory, one write and one read port.
  entry_t mem [MAX_PROCS];
  entry_t rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]     proc_cnt_r, proc_cnt_nxt;
  logic [CNT_W-1:0]     fin_cnt_r, fin_cnt_nxt;
  time_t                time_r, time_nxt;
  time_t                idle_r, idle_nxt;
  logic [MAX_PROCS-1:0] started_r, started_nxt;
  logic [MAX_PROCS-1:0] done_r, done_nxt;

  // Scan bookkeeping.
  logic [CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  entry_t           best_ent_r, best_ent_nxt;
  logic [ARR_W:0]   best_ab_r, best_ab_nxt;
  time_t            tick_ct_r, tick_ct_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [PID_W-1:0]    out_pid_r, out_pid_nxt;
  logic                out_completed_r, out_completed_nxt;
  time_t               out_ct_r, out_ct_nxt;
  time_t               out_tat_r, out_tat_nxt;
  time_t               out_wt_r, out_wt_nxt;
  time_t               out_rt_r, out_rt_nxt;
  time_t               out_idle_r, out_idle_nxt;
  logic                out_all_done_r, out_all_done_nxt;

  logic accept;
  logic is_cand;
  logic better;
  logic [BUR_W-1:0] rem_dec;
  logic             fin_now;
  time_t            start_val;
  logic [CNT_W:0]   load_pid;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Memory ports: read data is registered and arrives the cycle after the address.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_action != ACT_CLEAR && in_action != ACT_LOAD) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // The last row's compare lands in the cycle with no read issued.
        if (scan_idx_r == proc_cnt_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Candidate test for the row coming back from memory.
  assign is_cand = !done_r[cmp_idx_r] && (TIME_W'(rd_data_r.arrival) <= time_r);
  assign better  = !found_r
                || (rd_data_r.priority_lvl > best_ent_r.priority_lvl)
                || (rd_data_r.priority_lvl == best_ent_r.priority_lvl
                    && rd_data_r.arrival < best_ent_r.arrival);

  // Values for the write-back of the chosen row.
  assign rem_dec   = best_ent_r.remaining - BUR_W'(1);
  assign fin_now   = found_r && (rem_dec == '0);
  assign start_val = started_r[best_idx_r] ? best_ent_r.start_time : time_r;
  assign load_pid  = {1'b0, proc_cnt_r} + (CNT_W+1)'(1);

  // Datapath and result word.
  always_comb begin
    proc_cnt_nxt = proc_cnt_r;
    fin_cnt_nxt  = fin_cnt_r;
    time_nxt     = time_r;
    idle_nxt     = idle_r;
    started_nxt  = started_r;
    done_nxt     = done_r;
    scan_idx_nxt = scan_idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_ent_nxt = best_ent_r;
    best_ab_nxt  = best_ab_r;
    tick_ct_nxt  = tick_ct_r;

    mem_we    = 1'b0;
    mem_waddr = proc_cnt_r[IDX_W-1:0];
    mem_wdata = '{arrival: in_arrival, burst: in_burst, remaining: in_burst,
                  priority_lvl: in_priority_req, start_time: '0};
    mem_raddr = scan_idx_r[IDX_W-1:0];

    out_valid_nxt     = 1'b0;
    out_status_nxt    = out_status_r;
    out_pid_nxt       = out_pid_r;
    out_completed_nxt = out_completed_r;
    out_ct_nxt        = out_ct_r;
    out_tat_nxt       = out_tat_r;
    out_wt_nxt        = out_wt_r;
    out_rt_nxt        = out_rt_r;
    out_idle_nxt      = out_idle_r;
    out_all_done_nxt  = out_all_done_r;

    // Fold each returned row into the running best.
    if (cmp_vld_r && is_cand && better) begin
      found_nxt    = 1'b1;
      best_idx_nxt = cmp_idx_r;
      best_ent_nxt = rd_data_r;
      best_ab_nxt  = {1'b0, rd_data_r.arrival} + {1'b0, rd_data_r.burst};
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt     = 1'b1;
          out_pid_nxt       = '0;
          out_completed_nxt = 1'b0;
          out_ct_nxt        = '0;
          out_tat_nxt       = '0;
          out_wt_nxt        = '0;
          out_rt_nxt        = '0;
          out_idle_nxt      = idle_r;
          out_all_done_nxt  = (fin_cnt_r == proc_cnt_r);
          case (in_action)
            ACT_CLEAR: begin
              proc_cnt_nxt     = '0;
              fin_cnt_nxt      = '0;
              time_nxt         = '0;
              idle_nxt         = '0;
              started_nxt      = '0;
              done_nxt         = '0;
              out_status_nxt   = STAT_CLEARED;
              out_idle_nxt     = '0;
              out_all_done_nxt = 1'b1;
            end
            ACT_LOAD: begin
              if (proc_cnt_r >= CNT_MAX || in_burst == '0) begin
                out_status_nxt = STAT_REJECTED;
              end else begin
                mem_we       = 1'b1;
                proc_cnt_nxt = load_pid[CNT_W-1:0];
                started_nxt[proc_cnt_r[IDX_W-1:0]] = 1'b0;
                done_nxt[proc_cnt_r[IDX_W-1:0]]    = 1'b0;
                out_status_nxt   = STAT_LOADED;
                out_pid_nxt      = PID_W'(load_pid);
                out_all_done_nxt = 1'b0;
              end
            end
            default: begin
              // Tick: hold the result word until the scan ends.
              out_valid_nxt = 1'b0;
              scan_idx_nxt  = '0;
              found_nxt     = 1'b0;
              tick_ct_nxt   = sat_inc(time_r);
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_idx_r != proc_cnt_r) begin
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_idx_r[IDX_W-1:0];
        end
      end
      ST_FINISH: begin
        out_valid_nxt     = 1'b1;
        time_nxt          = tick_ct_r;
        out_completed_nxt = 1'b0;
        out_ct_nxt        = '0;
        out_tat_nxt       = '0;
        out_wt_nxt        = '0;
        out_rt_nxt        = '0;
        if (found_r) begin
          mem_we               = 1'b1;
          mem_waddr            = best_idx_r;
          mem_wdata            = best_ent_r;
          mem_wdata.remaining  = rem_dec;
          mem_wdata.start_time = start_val;
          started_nxt[best_idx_r] = 1'b1;
          out_status_nxt = STAT_RAN;
          out_pid_nxt    = PID_W'({1'b0, best_idx_r} + (IDX_W+1)'(1));
          out_idle_nxt   = idle_r;
          if (fin_now) begin
            done_nxt[best_idx_r] = 1'b1;
            fin_cnt_nxt       = fin_cnt_r + CNT_W'(1);
            out_completed_nxt = 1'b1;
            out_ct_nxt        = tick_ct_r;
            out_tat_nxt       = tick_ct_r - TIME_W'(best_ent_r.arrival);
            // Completion never precedes arrival, so this equals the
            // clamped turnaround minus burst.
            out_wt_nxt        = (tick_ct_r >= TIME_W'(best_ab_r))
                              ? tick_ct_r - TIME_W'(best_ab_r) : '0;
            out_rt_nxt        = start_val - TIME_W'(best_ent_r.arrival);
          end
          out_all_done_nxt = (fin_cnt_nxt == proc_cnt_r);
        end else begin
          idle_nxt         = sat_inc(idle_r);
          out_status_nxt   = STAT_IDLE;
          out_pid_nxt      = '0;
          out_idle_nxt     = idle_nxt;
          out_all_done_nxt = (fin_cnt_r == proc_cnt_r);
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      proc_cnt_r  <= '0;
      fin_cnt_r   <= '0;
      time_r      <= '0;
      idle_r      <= '0;
      started_r   <= '0;
      done_r      <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      proc_cnt_r  <= proc_cnt_nxt;
      fin_cnt_r   <= fin_cnt_nxt;
      time_r      <= time_nxt;
      idle_r      <= idle_nxt;
      started_r   <= started_nxt;
      done_r      <= done_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_idx_r      <= scan_idx_nxt;
    cmp_idx_r       <= cmp_idx_nxt;
    best_idx_r      <= best_idx_nxt;
    best_ent_r      <= best_ent_nxt;
    best_ab_r       <= best_ab_nxt;
    tick_ct_r       <= tick_ct_nxt;
    out_status_r    <= out_status_nxt;
    out_pid_r       <= out_pid_nxt;
    out_completed_r <= out_completed_nxt;
    out_ct_r        <= out_ct_nxt;
    out_tat_r       <= out_tat_nxt;
    out_wt_r        <= out_wt_nxt;
    out_rt_r        <= out_rt_nxt;
    out_idle_r      <= out_idle_nxt;
    out_all_done_r  <= out_all_done_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_pid             = out_pid_r;
  assign out_completed       = out_completed_r;
  assign out_completion_time = out_ct_r;
  assign out_turnaround      = out_tat_r;
  assign out_waiting         = out_wt_r;
  assign out_response        = out_rt_r;
  assign out_idle_ticks      = out_idle_r;
  assign out_all_done        = out_all_done_r;

  `PPS_ASSERT_NOW(a_fin_le_proc, 1'b1, fin_cnt_r <= proc_cnt_r,
    "finished count exceeds process count")
  `PPS_ASSERT_NOW(a_best_in_table, state_r == ST_FINISH && found_r,
    CNT_W'(best_idx_r) < proc_cnt_r, "chosen slot beyond table")
  `PPS_ASSERT_NEXT(a_finish_strobes, state_r == ST_FINISH,
    out_valid && state_r == ST_IDLE, "tick ended without a result")
  `PPS_ASSERT_NOW(a_completed_ran, out_valid && out_completed,
    out_status == STAT_RAN, "completion flagged on a non-run result")

endmodule

// ----- test/preemptive_priority_scheduler_tb.sv -----
module preemptive_priority_scheduler_tb
  import pps_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS  = 16;
  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_WORDS = 950;
  // Drain margin, grown with the table size to outlast a full-table tick.
  localparam int DRAIN_CYCLES = TABLE_SLOTS + 8;
  localparam int CYCLE_LIMIT  = 400000;

  // The spare action code runs a tick.
  localparam action_t ACT_SPARE = 2'd3;

  // One result word, laid out field by field.
  typedef struct packed {
    status_t             status;
    logic [PID_W-1:0]    pid;
    logic                completed;
    time_t               completion_time;
    time_t               turnaround;
    time_t               waiting;
    time_t               response;
    time_t               idle_ticks;
    logic                all_done;
  } sched_word_t;

  // Scheduler shadow: keeps its own process table, works out the result
  // word of every accepted command and checks the words that come back.
  class schedule_tracker;
    logic [ARR_W-1:0] slot_arrival[TABLE_SLOTS];
    logic [BUR_W-1:0] slot_burst[TABLE_SLOTS];
    logic [BUR_W-1:0] slot_left[TABLE_SLOTS];
    logic [PRI_W-1:0] slot_prio[TABLE_SLOTS];
    time_t            slot_first_run[TABLE_SLOTS];
    bit               slot_started[TABLE_SLOTS];
    bit               slot_done[TABLE_SLOTS];
    int unsigned      loaded;
    int unsigned      finished;
    time_t            clock_now;
    time_t            idle_count;
    sched_word_t      pending_words[$];
    int unsigned      errors;

    function new();
      errors = 0;
      clear_table();
    endfunction

    function void clear_table();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_started[i] = 1'b0;
        slot_done[i]    = 1'b0;
      end
      loaded     = 0;
      finished   = 0;
      clock_now  = '0;
      idle_count = '0;
    endfunction

    function void note_command(action_t act, logic [ARR_W-1:0] arr,
                               logic [BUR_W-1:0] bur, logic [PRI_W-1:0] prio);
      sched_word_t w;
      int          best;
      bit          found;
      time_t       tat;
      w     = '0;
      best  = 0;
      found = 1'b0;
      case (act)
        ACT_CLEAR: begin
          clear_table();
          w.status = STAT_CLEARED;
        end
        ACT_LOAD: begin
          if (loaded >= TABLE_SLOTS || bur == '0) begin
            w.status = STAT_REJECTED;
          end else begin
            slot_arrival[loaded] = arr;
            slot_burst[loaded]   = bur;
            slot_left[loaded]    = bur;
            slot_prio[loaded]    = prio;
            slot_started[loaded] = 1'b0;
            slot_done[loaded]    = 1'b0;
            loaded++;
            w.pid    = PID_W'(loaded);
            w.status = STAT_LOADED;
          end
        end
        default: begin
          for (int i = 0; i < loaded; i++) begin
            if (slot_done[i] || time_t'(slot_arrival[i]) > clock_now) continue;
            if (!found || slot_prio[i] > slot_prio[best] ||
                (slot_prio[i] == slot_prio[best] &&
                 slot_arrival[i] < slot_arrival[best])) begin
              best  = i;
              found = 1'b1;
            end
          end
          if (found) begin
            if (!slot_started[best]) begin
              slot_started[best]   = 1'b1;
              slot_first_run[best] = clock_now;
            end
            slot_left[best] = slot_left[best] - 1'b1;
            if (clock_now != TIME_MAX) clock_now = clock_now + 1;
            w.status = STAT_RAN;
            w.pid    = PID_W'(best + 1);
            if (slot_left[best] == '0) begin
              slot_done[best] = 1'b1;
              finished++;
              tat               = clock_now - time_t'(slot_arrival[best]);
              w.completed       = 1'b1;
              w.completion_time = clock_now;
              w.turnaround      = tat;
              w.waiting         = (tat >= time_t'(slot_burst[best])) ?
                                  tat - time_t'(slot_burst[best]) : '0;
              w.response        = slot_first_run[best] - time_t'(slot_arrival[best]);
            end
          end else begin
            if (idle_count != TIME_MAX) idle_count = idle_count + 1;
            if (clock_now != TIME_MAX) clock_now = clock_now + 1;
            w.status = STAT_IDLE;
          end
        end
      endcase
      w.idle_ticks = idle_count;
      w.all_done   = (finished == loaded);
      pending_words.push_back(w);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(sched_word_t got);
      sched_word_t want;
      if (pending_words.size() == 0) begin
        $error("result word with nothing pending: status %0d pid %0d",
               got.status, got.pid);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("pid", 32'(want.pid), 32'(got.pid));
      compare_field("completed", 32'(want.completed), 32'(got.completed));
      compare_field("completion_time", want.completion_time, got.completion_time);
      compare_field("turnaround", want.turnaround, got.turnaround);
      compare_field("waiting", want.waiting, got.waiting);
      compare_field("response", want.response, got.response);
      compare_field("idle_ticks", want.idle_ticks, got.idle_ticks);
      compare_field("all_done", 32'(want.all_done), 32'(got.all_done));
    endfunction
  endclass

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               start           = 1'b0;
  logic [ACT_W-1:0]   in_action       = '0;
  logic [ARR_W-1:0]   in_arrival      = '0;
  logic [BUR_W-1:0]   in_burst        = '0;
  logic [PRI_W-1:0]   in_priority_req = '0;
  logic               busy;
  logic               out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [PID_W-1:0]   out_pid;
  logic               out_completed;
  logic [TIME_W-1:0]  out_completion_time;
  logic [TIME_W-1:0]  out_turnaround;
  logic [TIME_W-1:0]  out_waiting;
  logic [TIME_W-1:0]  out_response;
  logic [TIME_W-1:0]  out_idle_ticks;
  logic               out_all_done;

  schedule_tracker tracker = new();
  int unsigned     sent_words = 0;   // accepted command words so far
  int unsigned     burst_left = 0;   // words left in the current sender burst
  int unsigned     cycle_count = 0;

  preemptive_priority_scheduler #(
    .MAX_PROCS(TABLE_SLOTS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_arrival          (in_arrival),
    .in_burst            (in_burst),
    .in_priority_req     (in_priority_req),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_pid             (out_pid),
    .out_completed       (out_completed),
    .out_completion_time (out_completion_time),
    .out_turnaround      (out_turnaround),
    .out_waiting         (out_waiting),
    .out_response        (out_response),
    .out_idle_ticks      (out_idle_ticks),
    .out_all_done        (out_all_done)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Bound the run: a hung handshake or a lost result word ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sample the result ports at the edge that ends the strobe cycle; the
  // values read here are the ones held during that cycle.
  always @(posedge clk) begin : watch_results
    sched_word_t got;
    if (rst_n && out_valid) begin
      got.status          = out_status;
      got.pid             = out_pid;
      got.completed       = out_completed;
      got.completion_time = out_completion_time;
      got.turnaround      = out_turnaround;
      got.waiting         = out_waiting;
      got.response        = out_response;
      got.idle_ticks      = out_idle_ticks;
      got.all_done        = out_all_done;
      tracker.check_word(got);
    end
  end

  // Hand one command word to the block. Open a new sender burst with a
  // random gap when the current one runs out, hold start high until the
  // block takes the word, then note it. Leave start high on return so a
  // back-to-back word needs no second assignment in the same step.
  task automatic push_command(action_t act, logic [ARR_W-1:0] arr,
                              logic [BUR_W-1:0] bur, logic [PRI_W-1:0] prio);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // Mix short bursts with long stretches of back-to-back words.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 30)
                                               : $urandom_range(1, 5);
    end
    burst_left--;
    start           <= 1'b1;
    in_action       <= act;
    in_arrival      <= arr;
    in_burst        <= bur;
    in_priority_req <= prio;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_command(act, arr, bur, prio);
    sent_words++;
  endtask

  // Mostly the regular tick code, now and then the spare one.
  function automatic action_t tick_code();
    return ($urandom_range(0, 9) == 0) ? ACT_SPARE : ACT_TICK;
  endfunction

  task automatic push_tick();
    push_command(tick_code(), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // One schedule: clear (usually), load a handful of processes that mostly
  // arrive near the current time, sprinkle ticks among the loads so later
  // arrivals preempt, tick until all are done or the budget runs out,
  // then up to two more. Long bursts and far arrivals hit the budget.
  task automatic run_schedule();
    int unsigned      n_procs;
    int unsigned      ticks;
    int unsigned      cap;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic [PRI_W-1:0] prio;
    if ($urandom_range(0, 9) < 8)
      push_command(ACT_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom));
    n_procs = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 18);
    for (int k = 0; k < n_procs; k++) begin
      arr = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                        : 16'(tracker.clock_now + $urandom_range(0, 12));
      case ($urandom_range(0, 19))
        0:       bur = '0;
        1:       bur = 16'($urandom);
        default: bur = 16'($urandom_range(1, 6));
      endcase
      // Low priorities crowd together to force ties.
      prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      push_command(ACT_LOAD, arr, bur, prio);
      if ($urandom_range(0, 4) == 0) push_tick();
    end
    cap   = $urandom_range(20, 70);
    ticks = 0;
    while (tracker.finished != tracker.loaded && ticks < cap) begin
      push_tick();
      ticks++;
    end
    repeat ($urandom_range(0, 2)) push_tick();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table straight out of reset: idle tick, all_done high.
    push_tick();
    // Zero burst is rejected.
    push_command(ACT_LOAD, 16'd4, 16'd0, 8'd9);
    // Field extremes: latest arrival, longest burst, lowest priority; it
    // never arrives here, so the tail ticks go idle.
    push_command(ACT_LOAD, 16'hFFFF, 16'hFFFF, 8'd0);
    push_command(ACT_LOAD, 16'd0, 16'd1, 8'hFF);
    // Equal priorities: earlier arrival wins, then the lower pid.
    push_command(ACT_LOAD, 16'd2, 16'd2, 8'd7);
    push_command(ACT_LOAD, 16'd1, 16'd2, 8'd7);
    push_command(ACT_LOAD, 16'd1, 16'd1, 8'd7);
    repeat (3) push_command(ACT_TICK, '0, '0, '0);
    push_command(ACT_SPARE, 16'hFFFF, 16'hFFFF, 8'hFF);
    repeat (3) push_command(ACT_TICK, '0, '0, '0);
    // Fill the table, then overflow it by one.
    for (int k = 0; k < TABLE_SLOTS - 5; k++)
      push_command(ACT_LOAD, 16'(k), 16'(k + 1), 8'(100 + 13 * k));
    push_command(ACT_LOAD, 16'd0, 16'd1, 8'hFF);
    // Scan a full table.
    push_command(ACT_TICK, '0, '0, '0);

    while (sent_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        // Noise: any action with unconstrained fields.
        repeat ($urandom_range(1, 5))
          push_command(action_t'($urandom_range(0, 3)), 16'($urandom),
                       16'($urandom), 8'($urandom));
      end else begin
        run_schedule();
      end
    end
    start <= 1'b0;

    // Drain: wait out the last result words, then a tick's latency more.
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pps_pkg.sv
rtl/preemptive_priority_scheduler.sv
test/preemptive_priority_scheduler_tb.sv
